// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the button click classifier.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that cause at one edge implies effect at the next edge.
`define ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);

`endif

// ===== sv/dbcc_pkg.sv =====
// Package for the debounced button click classifier: payload structs,
// event codes, register indexes and sizes. Depends on nothing.
`timescale 1ns / 1ps

package dbcc_pkg;

  localparam int CHANNELS = 10;
  localparam int CH_W = 4;
  localparam int TIME_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [TIME_W-1:0] GUARD_RESET = 32'd50;
  localparam logic [TIME_W-1:0] LONG_RESET = 32'd750;
  localparam logic [TIME_W-1:0] DOUBLE_RESET = 32'd750;

  localparam logic [CFG_IDX_W-1:0] CFG_GUARD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODES = 3'd5;

  localparam logic [1:0] MODE_BOTH = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_LOW = 2'd2;
  localparam logic [1:0] MODE_BUTTON = 2'd3;

  typedef enum logic [2:0] {
    KIND_LEVEL  = 3'd0,
    KIND_STATUS = 3'd1,
    KIND_LONG   = 3'd2,
    KIND_DOUBLE = 3'd3,
    KIND_SINGLE = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic              raw_level;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] report_channel;
    event_kind_t     event_kind;
    logic            asserted;
    logic            last_of_run;
  } out_item_t;

endpackage

// ===== sv/debounced_button_click_classifier_top.sv =====
// Top level of the debounced button click classifier: input register,
// per-channel debounce and click logic, and a small result queue.
// Depends on dbcc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block takes one sampled level per cycle while in_stall is low. A transaction
// is held in an input register, where the channel's kept state and timestamps are
// read, compared and updated, and its zero, one or two reports go into a four-entry
// result queue. The input register moves on only while the queue has room for two
// reports, so the sustained rate is one input transaction per cycle as long as the
// result side takes one report per cycle; a button release makes a status report
// and a click report. Configuration writes are always ready and take effect at the
// next cycle.
module debounced_button_click_classifier_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dbcc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dbcc_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [dbcc_pkg::TIME_W-1:0]     guard_r;
  logic [dbcc_pkg::TIME_W-1:0]     long_r;
  logic [dbcc_pkg::TIME_W-1:0]     double_r;
  logic [dbcc_pkg::CHANNELS-1:0]   enable_r;
  logic [dbcc_pkg::CHANNELS-1:0]   active_low_r;
  logic [2*dbcc_pkg::CHANNELS-1:0] modes_r;

  logic [dbcc_pkg::CHANNELS-1:0]   kept_r;
  logic [dbcc_pkg::TIME_W-1:0]     change_time_r [dbcc_pkg::CHANNELS];
  logic [dbcc_pkg::TIME_W-1:0]     release_time_r [dbcc_pkg::CHANNELS];

  logic                            stage_valid_r;
  dbcc_pkg::in_item_t              stage_r;

  dbcc_pkg::out_item_t             fifo_r [dbcc_pkg::FIFO_DEPTH];
  logic [dbcc_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [dbcc_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [dbcc_pkg::FIFO_CNT_W-1:0] cnt_r;
  logic [dbcc_pkg::FIFO_CNT_W-1:0] cnt_nxt;

  logic                            fire;
  logic                            pop;
  logic                            in_range;
  logic [dbcc_pkg::CH_W-1:0]       idx;
  logic                            ch_en;
  logic                            state;
  logic [1:0]                      mode;
  logic [dbcc_pkg::TIME_W-1:0]     delay;
  logic [dbcc_pkg::TIME_W-1:0]     since_release;
  logic                            change;
  logic                            is_button;
  logic                            level_pass;
  logic [1:0]                      push_n;
  dbcc_pkg::out_item_t             res0;
  dbcc_pkg::out_item_t             res1;
  dbcc_pkg::event_kind_t           click_kind;

  assign cfg_ready = 1'b1;

  assign fire = stage_valid_r && (cnt_r <= dbcc_pkg::FIFO_CNT_W'(dbcc_pkg::FIFO_DEPTH - 2));
  assign in_stall = stage_valid_r && !fire;
  assign pop = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data = fifo_r[rd_ptr_r];

  always_comb begin
    in_range = (stage_r.channel < dbcc_pkg::CH_W'(dbcc_pkg::CHANNELS));
    idx = in_range ? stage_r.channel : '0;
    ch_en = in_range && enable_r[idx];
    state = stage_r.raw_level ^ active_low_r[idx];
    mode = modes_r[{idx, 1'b0} +: 2];
    delay = stage_r.now_ms - change_time_r[idx];
    since_release = stage_r.now_ms - release_time_r[idx];
    change = ch_en && (delay > guard_r) && (state != kept_r[idx]);
    is_button = (mode == dbcc_pkg::MODE_BUTTON);
    level_pass = (mode == dbcc_pkg::MODE_BOTH)
              || ((mode == dbcc_pkg::MODE_HIGH) && stage_r.raw_level)
              || ((mode == dbcc_pkg::MODE_LOW) && !stage_r.raw_level);

    if (delay > long_r) begin
      click_kind = dbcc_pkg::KIND_LONG;
    end else if (since_release < double_r) begin
      click_kind = dbcc_pkg::KIND_DOUBLE;
    end else begin
      click_kind = dbcc_pkg::KIND_SINGLE;
    end

    res0.report_channel = stage_r.channel;
    res0.event_kind = is_button ? dbcc_pkg::KIND_STATUS : dbcc_pkg::KIND_LEVEL;
    res0.asserted = state;
    res0.last_of_run = !(is_button && !state);
    res1.report_channel = stage_r.channel;
    res1.event_kind = click_kind;
    res1.asserted = 1'b1;
    res1.last_of_run = 1'b1;

    push_n = 2'd0;
    if (fire && change) begin
      if (is_button) begin
        push_n = state ? 2'd1 : 2'd2;
      end else if (level_pass) begin
        push_n = 2'd1;
      end
    end

    cnt_nxt = cnt_r + dbcc_pkg::FIFO_CNT_W'(push_n) - dbcc_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_r <= dbcc_pkg::GUARD_RESET;
      long_r <= dbcc_pkg::LONG_RESET;
      double_r <= dbcc_pkg::DOUBLE_RESET;
      enable_r <= '0;
      active_low_r <= '0;
      modes_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dbcc_pkg::CFG_GUARD: guard_r <= cfg_data;
        dbcc_pkg::CFG_LONG: long_r <= cfg_data;
        dbcc_pkg::CFG_DOUBLE: double_r <= cfg_data;
        dbcc_pkg::CFG_ENABLE: enable_r <= cfg_data[dbcc_pkg::CHANNELS-1:0];
        dbcc_pkg::CFG_ACTIVE_LOW: active_low_r <= cfg_data[dbcc_pkg::CHANNELS-1:0];
        dbcc_pkg::CFG_MODES: modes_r <= cfg_data[2*dbcc_pkg::CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r <= '0;
      for (int i = 0; i < dbcc_pkg::CHANNELS; i++) begin
        change_time_r[i] <= '0;
        release_time_r[i] <= '0;
      end
    end else if (fire && change) begin
      kept_r[idx] <= state;
      change_time_r[idx] <= stage_r.now_ms;
      if (is_button && !state) begin
        release_time_r[idx] <= stage_r.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (!in_stall) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_r + dbcc_pkg::FIFO_PTR_W'(pop);
      wr_ptr_r <= wr_ptr_r + dbcc_pkg::FIFO_PTR_W'(push_n);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + dbcc_pkg::FIFO_PTR_W'(1)] <= res1;
    end
  end

  `ASSERT_CLK(a_cnt_bound, (cnt_r <= dbcc_pkg::FIFO_CNT_W'(dbcc_pkg::FIFO_DEPTH)), "queue overflow")
  `ASSERT_NEXT(a_pair_held, (push_n == 2'd2), (cnt_r >= 3'd2), "click report pair lost")
  `ASSERT_NEXT(a_off_silent, (fire && !ch_en), (cnt_r <= $past(cnt_r)), "report on idle channel")

endmodule
